### hw/rtl/mlfq_pkg.sv
// shared types and constants of the feedback queue scheduler
package mlfq_pkg;

    localparam int NUM_LEVELS = 4;
    localparam int LVL_W      = 2;
    localparam int PID_W      = 6;
    localparam int NUM_PIDS   = 64;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int QUANT_W    = 16;
    localparam int PLVL_W     = 3;
    localparam int QOUT_W     = 18;
    localparam int LIMIT_W    = QUANT_W + 3;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADMIT   = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_REQUEUE = 2'd2,
        CMD_SELECT  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LV_RD,
        S_LV_SET,
        S_PUSH,
        S_AG_CHK,
        S_AG_PID,
        S_AG_CMP,
        S_PICK_SEL,
        S_PK_RD,
        S_PK_PID,
        S_PK_LV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_head;
        logic take_head;
        logic rd_plv;
        logic plv_at_head;
        logic set_lv_plv;
        logic stamp_rd;
        logic push;
        logic promote;
        logic lv_inc;
        logic lv_pick;
        logic pop;
        logic res_ok;
        logic res_empty;
        logic res_full;
        logic res_pick;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic lv_full;
        logic lv_empty;
        logic lv_last;
        logic above_full;
        logic aged;
        logic any_ready;
    } t_dp_stat;

endpackage

### hw/rtl/mlfq_req_if.sv
// request channel: command beat into the scheduler
interface mlfq_req_if #(
    parameter int TIME_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic [mlfq_pkg::CMD_W-1:0]   cmd;
    logic [mlfq_pkg::PID_W-1:0]   pid;
    logic [TIME_BITS-1:0]         now;

    modport source (output valid, output cmd, output pid, output now, input ready);
    modport sink   (input valid, input cmd, input pid, input now, output ready);
endinterface

### hw/rtl/mlfq_rsp_if.sv
// response channel: result beat out of the scheduler
interface mlfq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mlfq_pkg::STAT_W-1:0]   status;
    logic [mlfq_pkg::PID_W-1:0]    picked_pid;
    logic [mlfq_pkg::PLVL_W-1:0]   picked_level;
    logic [mlfq_pkg::QOUT_W-1:0]   quantum_out;

    modport source (output valid, output status, output picked_pid, output picked_level,
                    output quantum_out, input ready);
    modport sink   (input valid, input status, input picked_pid, input picked_level,
                    input quantum_out, output ready);
endinterface

### hw/rtl/mlfq_ram.sv
// generic single write port ram with registered read
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/mlfq_ctrl.sv
// scheduler sequencer: walks admit, enqueue/requeue, aging and pick steps
module mlfq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mlfq_pkg::t_cmd     i_in_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  mlfq_pkg::t_dp_stat i_stat,
    output mlfq_pkg::t_dp_cmd  o_cmd
);
    mlfq_pkg::t_state r_state;
    mlfq_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlfq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            mlfq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_in_cmd)
                        mlfq_pkg::CMD_SELECT: n_state = mlfq_pkg::S_AG_CHK;
                        mlfq_pkg::CMD_ADMIT:  n_state = mlfq_pkg::S_PUSH;
                        default:              n_state = mlfq_pkg::S_LV_RD;
                    endcase
                end
            end
            mlfq_pkg::S_LV_RD: begin
                o_cmd.rd_plv = 1'b1;
                n_state      = mlfq_pkg::S_LV_SET;
            end
            mlfq_pkg::S_LV_SET: begin
                o_cmd.set_lv_plv = 1'b1;
                n_state          = mlfq_pkg::S_PUSH;
            end
            mlfq_pkg::S_PUSH: begin
                if (i_stat.lv_full) begin
                    o_cmd.res_full = 1'b1;
                end else begin
                    o_cmd.push   = 1'b1;
                    o_cmd.res_ok = 1'b1;
                end
                n_state = mlfq_pkg::S_DONE;
            end
            mlfq_pkg::S_AG_CHK: begin
                if (!i_stat.lv_empty) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = mlfq_pkg::S_AG_PID;
                end else if (i_stat.lv_last) begin
                    n_state = mlfq_pkg::S_PICK_SEL;
                end else begin
                    o_cmd.lv_inc = 1'b1;
                end
            end
            mlfq_pkg::S_AG_PID: begin
                o_cmd.take_head = 1'b1;
                o_cmd.stamp_rd  = 1'b1;
                n_state         = mlfq_pkg::S_AG_CMP;
            end
            mlfq_pkg::S_AG_CMP: begin
                if (i_stat.aged && !i_stat.above_full) begin
                    o_cmd.promote = 1'b1;
                    n_state       = mlfq_pkg::S_AG_CHK;
                end else if (i_stat.lv_last) begin
                    n_state = mlfq_pkg::S_PICK_SEL;
                end else begin
                    o_cmd.lv_inc = 1'b1;
                    n_state      = mlfq_pkg::S_AG_CHK;
                end
            end
            mlfq_pkg::S_PICK_SEL: begin
                if (i_stat.any_ready) begin
                    o_cmd.lv_pick = 1'b1;
                    n_state       = mlfq_pkg::S_PK_RD;
                end else begin
                    o_cmd.res_empty = 1'b1;
                    n_state         = mlfq_pkg::S_DONE;
                end
            end
            mlfq_pkg::S_PK_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = mlfq_pkg::S_PK_PID;
            end
            mlfq_pkg::S_PK_PID: begin
                o_cmd.take_head   = 1'b1;
                o_cmd.pop         = 1'b1;
                o_cmd.rd_plv      = 1'b1;
                o_cmd.plv_at_head = 1'b1;
                n_state           = mlfq_pkg::S_PK_LV;
            end
            mlfq_pkg::S_PK_LV: begin
                o_cmd.res_pick = 1'b1;
                n_state        = mlfq_pkg::S_DONE;
            end
            mlfq_pkg::S_DONE: begin
                // hand over once the output beat slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = mlfq_pkg::S_IDLE;
                end
            end
            default: n_state = mlfq_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

### hw/rtl/mlfq_dp.sv
// scheduler datapath: level rings, per-pid level and stamp stores, result registers
module mlfq_dp #(
    parameter int MAX_PROC  = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mlfq_pkg::QUANT_W-1:0]    i_cfg_wdata,
    input  logic [mlfq_pkg::CMD_W-1:0]      i_in_cmd,
    input  logic [mlfq_pkg::PID_W-1:0]      i_in_pid,
    input  logic [TIME_BITS-1:0]            i_in_now,
    input  mlfq_pkg::t_dp_cmd               i_cmd,
    output mlfq_pkg::t_dp_stat              o_stat,
    output logic [mlfq_pkg::STAT_W-1:0]     o_status,
    output logic [mlfq_pkg::PID_W-1:0]      o_picked_pid,
    output logic [mlfq_pkg::PLVL_W-1:0]     o_picked_level,
    output logic [mlfq_pkg::QOUT_W-1:0]     o_quantum_out
);
    localparam int LW    = mlfq_pkg::LVL_W;
    localparam int PW    = mlfq_pkg::PID_W;
    localparam int NL    = mlfq_pkg::NUM_LEVELS;
    localparam int IW    = $clog2(MAX_PROC);
    localparam int CNTW  = $clog2(MAX_PROC + 1);
    localparam int QSD   = NL << IW;
    localparam int LIMW  = mlfq_pkg::LIMIT_W;
    localparam int CMPW  = (TIME_BITS > LIMW) ? TIME_BITS : LIMW;
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_PROC);

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx);
        f_next = (idx == IW'(MAX_PROC - 1)) ? '0 : idx + 1'b1;
    endfunction

    mlfq_pkg::t_cmd                 r_cmd;
    logic [PW-1:0]                  r_pid;
    logic [TIME_BITS-1:0]           r_now;
    logic [LW-1:0]                  r_lv;
    logic [IW-1:0]                  r_head  [NL];
    logic [IW-1:0]                  r_tail  [NL];
    logic [CNTW-1:0]                r_count [NL];
    logic [mlfq_pkg::QUANT_W-1:0]   r_quantum;

    logic [mlfq_pkg::STAT_W-1:0]    r_res_status;
    logic [PW-1:0]                  r_res_pid;
    logic [mlfq_pkg::PLVL_W-1:0]    r_res_level;
    logic [mlfq_pkg::QOUT_W-1:0]    r_res_quant;
    logic [mlfq_pkg::STAT_W-1:0]    r_out_status;
    logic [PW-1:0]                  r_out_pid;
    logic [mlfq_pkg::PLVL_W-1:0]    r_out_level;
    logic [mlfq_pkg::QOUT_W-1:0]    r_out_quant;

    logic [LW-1:0]                  w_lv_up;
    logic [LW-1:0]                  w_first;
    logic                           w_any;
    logic                           w_qs_we;
    logic [LW+IW-1:0]               w_qs_waddr;
    logic [LW+IW-1:0]               w_qs_raddr;
    logic [PW-1:0]                  w_qs_rdata;
    logic                           w_wr;
    logic [LW-1:0]                  w_plv_wdata;
    logic [PW-1:0]                  w_plv_raddr;
    logic [LW-1:0]                  w_plv_rdata;
    logic [TIME_BITS-1:0]           w_st_rdata;
    logic [TIME_BITS-1:0]           w_wait;
    logic [LIMW-1:0]                w_limit;
    logic [LIMW-1:0]                w_q;
    logic [mlfq_pkg::PLVL_W-1:0]    w_pick_level;

    assign w_lv_up = r_lv - 1'b1;

    always_comb begin
        w_first = '0;
        w_any   = 1'b0;
        for (int l = NL - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                w_first = LW'(l);
                w_any   = 1'b1;
            end
        end
    end

    // rings share one store, one address block per level
    assign w_qs_we    = i_cmd.push || i_cmd.promote;
    assign w_qs_waddr = i_cmd.promote ? {w_lv_up, r_tail[w_lv_up]} : {r_lv, r_tail[r_lv]};
    assign w_qs_raddr = {r_lv, r_head[r_lv]};
    assign w_wr       = w_qs_we;
    assign w_plv_wdata = i_cmd.promote ? w_lv_up : r_lv;
    assign w_plv_raddr = i_cmd.plv_at_head ? w_qs_rdata : r_pid;

    mlfq_ram #(.WIDTH(PW), .DEPTH(QSD)) u_queue_store (
        .i_clk   (i_clk),
        .i_we    (w_qs_we),
        .i_waddr (w_qs_waddr),
        .i_wdata (r_pid),
        .i_re    (i_cmd.rd_head),
        .i_raddr (w_qs_raddr),
        .o_rdata (w_qs_rdata)
    );

    mlfq_ram #(.WIDTH(LW), .DEPTH(mlfq_pkg::NUM_PIDS)) u_proc_level (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_pid),
        .i_wdata (w_plv_wdata),
        .i_re    (i_cmd.rd_plv),
        .i_raddr (w_plv_raddr),
        .o_rdata (w_plv_rdata)
    );

    mlfq_ram #(.WIDTH(TIME_BITS), .DEPTH(mlfq_pkg::NUM_PIDS)) u_ready_stamp (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_pid),
        .i_wdata (r_now),
        .i_re    (i_cmd.stamp_rd),
        .i_raddr (w_qs_rdata),
        .o_rdata (w_st_rdata)
    );

    // aging threshold: 4, 6 or 8 quanta for levels 2, 3, 4
    assign w_q    = LIMW'(r_quantum);
    assign w_wait = r_now - w_st_rdata;
    always_comb begin
        unique case (r_lv)
            2'd1:    w_limit = w_q << 2;
            2'd2:    w_limit = (w_q << 2) + (w_q << 1);
            default: w_limit = w_q << 3;
        endcase
    end

    assign w_pick_level = {1'b0, w_plv_rdata} + 1'b1;

    assign o_stat.lv_full    = (r_count[r_lv] == FULL_CNT);
    assign o_stat.lv_empty   = (r_count[r_lv] == '0);
    assign o_stat.lv_last    = (r_lv == LW'(NL - 1));
    assign o_stat.above_full = (r_count[w_lv_up] == FULL_CNT);
    assign o_stat.aged       = (CMPW'(w_wait) >= CMPW'(w_limit));
    assign o_stat.any_ready  = w_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= mlfq_pkg::QUANTUM_RESET;
            r_lv      <= '0;
            for (int l = 0; l < NL; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_lv <= (mlfq_pkg::t_cmd'(i_in_cmd) == mlfq_pkg::CMD_SELECT) ? 2'd1 : 2'd0;
            end else if (i_cmd.set_lv_plv) begin
                r_lv <= (r_cmd == mlfq_pkg::CMD_REQUEUE && w_plv_rdata != 2'd3) ?
                        w_plv_rdata + 1'b1 : w_plv_rdata;
            end else if (i_cmd.lv_inc) begin
                r_lv <= r_lv + 1'b1;
            end else if (i_cmd.lv_pick) begin
                r_lv <= w_first;
            end
            for (int l = 0; l < NL; l++) begin
                if ((i_cmd.push && r_lv == LW'(l)) || (i_cmd.promote && w_lv_up == LW'(l))) begin
                    r_tail[l]  <= f_next(r_tail[l]);
                    r_count[l] <= r_count[l] + 1'b1;
                end
                if ((i_cmd.pop || i_cmd.promote) && r_lv == LW'(l)) begin
                    r_head[l]  <= f_next(r_head[l]);
                    r_count[l] <= r_count[l] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= mlfq_pkg::t_cmd'(i_in_cmd);
            r_pid <= i_in_pid;
            r_now <= i_in_now;
        end else if (i_cmd.take_head) begin
            r_pid <= w_qs_rdata;
        end
        if (i_cmd.res_ok || i_cmd.res_full || i_cmd.res_empty) begin
            r_res_pid   <= '0;
            r_res_level <= '0;
            r_res_quant <= '0;
        end
        if (i_cmd.res_ok) begin
            r_res_status <= mlfq_pkg::ST_OK;
        end
        if (i_cmd.res_full) begin
            r_res_status <= mlfq_pkg::ST_FULL;
        end
        if (i_cmd.res_empty) begin
            r_res_status <= mlfq_pkg::ST_EMPTY;
        end
        if (i_cmd.res_pick) begin
            r_res_status <= mlfq_pkg::ST_OK;
            r_res_pid    <= r_pid;
            r_res_level  <= w_pick_level;
            r_res_quant  <= mlfq_pkg::QOUT_W'(r_quantum) * mlfq_pkg::QOUT_W'(w_pick_level);
        end
        if (i_cmd.commit) begin
            r_out_status <= r_res_status;
            r_out_pid    <= r_res_pid;
            r_out_level  <= r_res_level;
            r_out_quant  <= r_res_quant;
        end
    end

    assign o_status       = r_out_status;
    assign o_picked_pid   = r_out_pid;
    assign o_picked_level = r_out_level;
    assign o_quantum_out  = r_out_quant;
endmodule

### hw/rtl/mlfq_scheduler_with_aging.sv
// top level of the four-level feedback queue scheduler with aging
// One command beat in, one result beat out, one command at a time. Admit pushes
// straight into level 1; enqueue and requeue first read the stored level from
// its ram. A select first walks the aging of levels 2..4, promoting each head
// that has waited long enough while the level above has room, and then picks
// the head of the highest nonempty level, or reports empty when nothing is
// ready. Every aging step reads the head id from the ring ram, then its stamp
// from the stamp ram, then compares the wait against the level's threshold; an
// empty level is skipped without reads. A finished result sits in the output
// register while the next command is taken; the sequencer stalls only at its
// last step if that register is still occupied. No pass after reset; the rings
// start empty.
module mlfq_scheduler_with_aging #(
    parameter int MAX_PROC  = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mlfq_pkg::QUANT_W-1:0] i_cfg_wdata,
    mlfq_req_if.sink                     i_req,
    mlfq_rsp_if.source                   o_rsp
);
    mlfq_pkg::t_dp_cmd  w_cmd;
    mlfq_pkg::t_dp_stat w_stat;

    mlfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_cmd    (mlfq_pkg::t_cmd'(i_req.cmd)),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mlfq_dp #(.MAX_PROC(MAX_PROC), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_cmd       (i_req.cmd),
        .i_in_pid       (i_req.pid),
        .i_in_now       (i_req.now),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_status       (o_rsp.status),
        .o_picked_pid   (o_rsp.picked_pid),
        .o_picked_level (o_rsp.picked_level),
        .o_quantum_out  (o_rsp.quantum_out)
    );
endmodule

### bench/mlfq_sched_checker.sv
// scoreboard for the feedback queue scheduler: predicts each result beat and compares it
module mlfq_sched_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mlfq_pkg::QUANT_W-1:0] i_cfg_wdata,
    mlfq_req_if                          req,
    mlfq_rsp_if                          rsp,
    output int                           o_fails,
    output int                           o_pending,
    output int                           o_beats,
    output int                           o_promoted,
    output int                           o_full,
    output int                           o_empty
);
    timeunit 1ns;
    timeprecision 1ps;
    import mlfq_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PID_W-1:0]   pid;
        logic [PLVL_W-1:0]  level;
        logic [QOUT_W-1:0]  quantum;
    } t_sched_result;

    logic [PID_W-1:0]   ring_ids [NUM_LEVELS][DEPTH];
    int                 ring_head [NUM_LEVELS];
    int                 ring_tail [NUM_LEVELS];
    int                 ring_fill [NUM_LEVELS];
    logic [LVL_W-1:0]   pid_level [NUM_PIDS];
    logic [31:0]        pid_stamp [NUM_PIDS];
    bit                 known [NUM_PIDS];
    logic [QUANT_W-1:0] quantum;
    t_sched_result      results_due [$];

    function automatic bit ring_enter(int lv, logic [PID_W-1:0] p, logic [31:0] t);
        if (ring_fill[lv] >= DEPTH) return 0;
        ring_ids[lv][ring_tail[lv]] = p;
        ring_tail[lv] = (ring_tail[lv] + 1) % DEPTH;
        ring_fill[lv]++;
        pid_level[p] = lv[LVL_W-1:0];
        pid_stamp[p] = t;
        known[p] = 1;
        return 1;
    endfunction

    function automatic logic [PID_W-1:0] ring_take(int lv);
        logic [PID_W-1:0] p;
        p = ring_ids[lv][ring_head[lv]];
        ring_head[lv] = (ring_head[lv] + 1) % DEPTH;
        ring_fill[lv]--;
        return p;
    endfunction

    function automatic t_sched_result schedule(t_cmd c, logic [PID_W-1:0] p, logic [31:0] t);
        t_sched_result r;
        int lv;
        logic [31:0] lim;
        logic [PID_W-1:0] hp;
        logic [2:0] lvl;
        r = '0;
        if (c == CMD_SELECT) begin
            // aging walk over levels 2..4, each aged head moves up one level while the level above has room
            for (int a = 1; a < NUM_LEVELS; a++) begin
                lim = quantum * ((a == 1) ? 4 : (a == 2) ? 6 : 8);
                while (ring_fill[a] > 0) begin
                    hp = ring_ids[a][ring_head[a]];
                    if (t - pid_stamp[hp] < lim) break;
                    if (ring_fill[a-1] >= DEPTH) break;
                    hp = ring_take(a);
                    void'(ring_enter(a - 1, hp, t));
                    o_promoted++;
                end
            end
            r.status = ST_EMPTY;
            for (int a = 0; a < NUM_LEVELS; a++) begin
                if (ring_fill[a] > 0) begin
                    hp = ring_take(a);
                    lvl = {1'b0, pid_level[hp]} + 3'd1;
                    r.status = ST_OK;
                    r.pid = hp;
                    r.level = lvl;
                    r.quantum = QOUT_W'(quantum) * QOUT_W'(lvl);
                    break;
                end
            end
            if (r.status == ST_EMPTY) o_empty++;
            return r;
        end
        if (c == CMD_ADMIT) lv = 0;
        else begin
            lv = pid_level[p];
            if (c == CMD_REQUEUE && lv < 3) lv++;
        end
        if (!ring_enter(lv, p, t)) begin
            r.status = ST_FULL;
            o_full++;
        end
        return r;
    endfunction

    task automatic report(string field, longint want, longint got);
        $display("mismatch on beat %0d: %s expected %0d got %0d", o_beats, field, want, got);
        o_fails++;
    endtask

    initial begin
        o_fails = 0;
        o_pending = 0;
        o_beats = 0;
        o_promoted = 0;
        o_full = 0;
        o_empty = 0;
    end

    always @(posedge i_clk) begin
        t_sched_result want;
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_LEVELS; a++) begin
                ring_head[a] = 0;
                ring_tail[a] = 0;
                ring_fill[a] = 0;
            end
            for (int p = 0; p < NUM_PIDS; p++) known[p] = 0;
            quantum = QUANTUM_RESET;
            results_due.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                o_beats++;
                if (results_due.size() == 0) begin
                    report("unexpected result, status", -1, rsp.status);
                end else begin
                    want = results_due.pop_front();
                    if (rsp.status != want.status) report("status", want.status, rsp.status);
                    if (rsp.picked_pid != want.pid) report("picked_pid", want.pid, rsp.picked_pid);
                    if (rsp.picked_level != want.level)
                        report("picked_level", want.level, rsp.picked_level);
                    if (rsp.quantum_out != want.quantum)
                        report("quantum_out", want.quantum, rsp.quantum_out);
                end
            end
            if (req.valid && req.ready)
                results_due.push_back(schedule(t_cmd'(req.cmd), req.pid, req.now));
            if (i_cfg_we) quantum = i_cfg_wdata;
        end
        o_pending = results_due.size();
    end
endmodule

### bench/mlfq_scheduler_with_aging_tb.sv
// top of the scheduler testbench: clock, reset, stimulus and verdict
module mlfq_scheduler_with_aging_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlfq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [QUANT_W-1:0] cfg_wdata = '0;

    mlfq_req_if req ();
    mlfq_rsp_if rsp ();

    int fails, pending, beats, promoted, full_hits, empty_hits;
    int snd_idle = 0, rsp_idle = 0;
    int phase = 0;
    int hold_left = 0;
    bit held = 0;
    int idle_cycles = 0;
    int items_sent = 0;
    logic [31:0] clock_now;
    logic [QUANT_W-1:0] cur_quantum = QUANTUM_RESET;

    mlfq_scheduler_with_aging dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req),
        .o_rsp       (rsp)
    );

    mlfq_sched_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .req         (req),
        .rsp         (rsp),
        .o_fails     (fails),
        .o_pending   (pending),
        .o_beats     (beats),
        .o_promoted  (promoted),
        .o_full      (full_hits),
        .o_empty     (empty_hits)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        req.valid = 1'b0;
        req.cmd = '0;
        req.pid = '0;
        req.now = '0;
    end

    // receiver: random stalls, plus one long hold-off when the last phase starts
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp.ready = 1'b0;
                hold_left--;
            end else if (phase == 3 && !held) begin
                held = 1;
                hold_left = 300;
                rsp.ready = 1'b0;
            end else begin
                rsp.ready = ($urandom_range(99) >= rsp_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(t_cmd c, logic [PID_W-1:0] p, logic [31:0] t);
        while ($urandom_range(99) < snd_idle) begin
            req.valid = 1'b0;
            @(negedge i_clk);
        end
        req.valid = 1'b1;
        req.cmd = c;
        req.pid = p;
        req.now = t;
        do @(posedge i_clk); while (!req.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // only ids that already hold a stored level may be enqueued or requeued
    task automatic send_stored(t_cmd c, logic [31:0] t);
        logic [PID_W-1:0] p;
        for (int k = 0; k < 64; k++) begin
            p = PID_W'($urandom_range(63));
            if (chk.known[p]) begin
                send(c, p, t);
                return;
            end
        end
        send(CMD_ADMIT, p, t);
    endtask

    task automatic step_clock();
        if ($urandom_range(99) < 5) clock_now = $urandom;
        else clock_now += $urandom_range(0, 3 * int'(cur_quantum) + 2);
    endtask

    task automatic drain_and_set(logic [QUANT_W-1:0] q);
        req.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_wdata = q;
        cur_quantum = q;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_items(int n);
        int stop, mode, len;
        stop = items_sent + n;
        while (items_sent < stop) begin
            mode = $urandom_range(99);
            if (mode < 10) begin
                // flood level 1 past its depth
                len = $urandom_range(50, 70);
                repeat (len) begin
                    clock_now += $urandom_range(0, 2);
                    if ($urandom_range(3) == 0) send_stored(CMD_ENQUEUE, clock_now);
                    else send(CMD_ADMIT, PID_W'($urandom_range(63)), clock_now);
                end
            end else if (mode < 22) begin
                len = $urandom_range(10, 40);
                repeat (len) begin
                    step_clock();
                    send(CMD_SELECT, PID_W'($urandom_range(63)), clock_now);
                end
            end else begin
                repeat (20) begin
                    step_clock();
                    mode = $urandom_range(99);
                    if (mode < 25) send(CMD_ADMIT, PID_W'($urandom_range(63)), clock_now);
                    else if (mode < 45) send_stored(CMD_ENQUEUE, clock_now);
                    else if (mode < 65) send_stored(CMD_REQUEUE, clock_now);
                    else send(CMD_SELECT, PID_W'($urandom_range(63)), clock_now);
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty select, id extremes, demotion to the floor, aging, wrap of now
        send(CMD_SELECT, 6'd0, 32'd0);
        send(CMD_ADMIT, 6'd0, 32'd0);
        send(CMD_ADMIT, 6'd63, 32'hFFFF_FFF0);
        send(CMD_ENQUEUE, 6'd63, 32'hFFFF_FFFF);
        send(CMD_REQUEUE, 6'd63, 32'hFFFF_FFFF);
        send(CMD_REQUEUE, 6'd0, 32'd5);
        send(CMD_REQUEUE, 6'd0, 32'd6);
        send(CMD_REQUEUE, 6'd0, 32'd7);
        send(CMD_REQUEUE, 6'd0, 32'd8);
        send(CMD_REQUEUE, 6'd0, 32'd9);
        send(CMD_SELECT, 6'd63, 32'd10);
        send(CMD_SELECT, 6'd0, 32'd200);
        send(CMD_SELECT, 6'd0, 32'd400);
        send(CMD_SELECT, 6'd0, 32'd1000);
        send(CMD_SELECT, 6'd0, 32'd1000);
        send(CMD_SELECT, 6'd0, 32'd1000);
        send(CMD_ADMIT, 6'd42, 32'h8000_0000);
        send(CMD_REQUEUE, 6'd42, 32'h8000_0000);
        send(CMD_REQUEUE, 6'd42, 32'h8000_0001);
        send(CMD_REQUEUE, 6'd42, 32'h8000_0002);
        send(CMD_SELECT, 6'd21, 32'h7FFF_FFFF);
        send(CMD_SELECT, 6'd21, 32'h0000_0000);

        clock_now = $urandom;
        drain_and_set(16'd1);
        phase = 1;
        snd_idle = 9;
        rsp_idle = 49;
        random_items(300);

        drain_and_set(16'd65535);
        phase = 2;
        snd_idle = 49;
        rsp_idle = 9;
        random_items(300);

        drain_and_set(QUANT_W'($urandom_range(2, 40)));
        phase = 3;
        snd_idle = 0;
        rsp_idle = 0;
        random_items(300);

        req.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        $display("covered %0d commands and %0d results over quanta 10, 1, 65535 and %0d",
                 items_sent, beats, cur_quantum);
        $display("aging promotions %0d, full-level rejects %0d, empty selects %0d",
                 promoted, full_hits, empty_hits);
        if (fails == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
